// ===== design/dqd_pkg.sv =====
// Package for the debounced quadrature decoder.
// Holds the field width, the history constants, the step codes and the
// quadrature table and the result struct. No dependencies.
package dqd_pkg;

   localparam int unsigned FIELD_BITS = 4;
   localparam int unsigned HIST_BITS  = 3;

   localparam logic [HIST_BITS-1:0] HIST_ALL_ONES  = 3'b111;
   localparam logic [HIST_BITS-1:0] HIST_ALL_ZEROS = 3'b000;

   typedef logic [FIELD_BITS-1:0] level_vec_type;

   typedef enum logic [1:0] {
      STEP_NONE  = 2'b00,
      STEP_LEFT  = 2'b01,
      STEP_RIGHT = 2'b10
   } step_code_type;

   // Indexed by {previous pair, new pair}, each pair being {B, A}.
   localparam step_code_type QUAD_TABLE [16] = '{
      STEP_NONE,  STEP_RIGHT, STEP_LEFT,  STEP_NONE,
      STEP_LEFT,  STEP_NONE,  STEP_NONE,  STEP_RIGHT,
      STEP_RIGHT, STEP_NONE,  STEP_NONE,  STEP_LEFT,
      STEP_NONE,  STEP_LEFT,  STEP_RIGHT, STEP_NONE
   };

   typedef struct packed {
      level_vec_type left_steps;
      level_vec_type right_steps;
   } result_type;

endpackage

// ===== design/dqd_if.sv =====
// Request and response channel interfaces of the quadrature decoder.
// Depends on dqd_pkg for the level vector type.
interface dqd_req_if;
   logic                   valid;
   logic                   ready;
   dqd_pkg::level_vec_type a_levels;
   dqd_pkg::level_vec_type b_levels;

   modport source (output valid, output a_levels, output b_levels, input ready);
   modport sink   (input valid, input a_levels, input b_levels, output ready);
endinterface

interface dqd_rsp_if;
   logic                   valid;
   logic                   ready;
   dqd_pkg::level_vec_type left_steps;
   dqd_pkg::level_vec_type right_steps;

   modport source (output valid, output left_steps, output right_steps, input ready);
   modport sink   (input valid, input left_steps, input right_steps, output ready);
endinterface

// ===== design/dqd_lane.sv =====
// One encoder lane: three-sample A and B histories, the last settled pair
// and the quadrature table lookup. Depends on dqd_pkg.
module dqd_lane (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  logic                   enable,
   input  logic                   a_level,
   input  logic                   b_level,
   output dqd_pkg::step_code_type step
);

   logic [dqd_pkg::HIST_BITS-1:0] a_hist_ff, a_hist_in;
   logic [dqd_pkg::HIST_BITS-1:0] b_hist_ff, b_hist_in;
   logic [1:0]                    pair_ff, pair_in;
   logic [1:0]                    new_pair;
   logic                          settled;
   logic                          update;

   always_comb begin
      a_hist_in = {a_hist_ff[dqd_pkg::HIST_BITS-2:0], a_level};
      b_hist_in = {b_hist_ff[dqd_pkg::HIST_BITS-2:0], b_level};
      settled   = ((a_hist_in == dqd_pkg::HIST_ALL_ZEROS) ||
                   (a_hist_in == dqd_pkg::HIST_ALL_ONES)) &&
                  ((b_hist_in == dqd_pkg::HIST_ALL_ZEROS) ||
                   (b_hist_in == dqd_pkg::HIST_ALL_ONES));
      new_pair  = {b_hist_in == dqd_pkg::HIST_ALL_ONES,
                   a_hist_in == dqd_pkg::HIST_ALL_ONES};
      pair_in   = settled ? new_pair : pair_ff;
      update    = accept && enable;
      step      = (enable && settled) ? dqd_pkg::QUAD_TABLE[{pair_ff, new_pair}]
                                      : dqd_pkg::STEP_NONE;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_hist_ff <= '0;
         b_hist_ff <= '0;
         pair_ff   <= '0;
      end else if (update) begin
         a_hist_ff <= a_hist_in;
         b_hist_ff <= b_hist_in;
         pair_ff   <= pair_in;
      end
   end

   // A disabled lane keeps its whole state through a request.
   assert property (@(posedge clock) disable iff (reset)
      !enable |=> $stable(a_hist_ff) && $stable(b_hist_ff) && $stable(pair_ff))
      else $error("disabled lane changed its state");

   // The settled pair only moves when the new histories have settled.
   assert property (@(posedge clock) disable iff (reset)
      update && !settled |=> $stable(pair_ff))
      else $error("pair moved on an unsettled sample");

   // No step is reported from an unsettled sample.
   assert property (@(posedge clock) disable iff (reset)
      !settled |-> step == dqd_pkg::STEP_NONE)
      else $error("step reported while unsettled");

endmodule

// ===== design/dqd_merge.sv =====
// Merging stage: gathers the lane steps into left and right vectors and
// holds them in an output register backed by a skid register.
// Depends on dqd_pkg and dqd_if.
module dqd_merge #(
   parameter int unsigned LANE_COUNT = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  dqd_pkg::step_code_type steps [LANE_COUNT],
   output logic                   in_ready,
   dqd_rsp_if.source              rsp_ch
);

   dqd_pkg::result_type merged;
   dqd_pkg::result_type out_data_ff, out_data_in;
   dqd_pkg::result_type skid_data_ff;
   logic                out_valid_ff, out_valid_in;
   logic                skid_valid_ff, skid_valid_in;
   logic                pop;
   logic                load_out;
   logic                load_skid;

   always_comb begin
      merged = '0;
      for (int i = 0; i < LANE_COUNT; i++) begin
         merged.left_steps[i]  = (steps[i] == dqd_pkg::STEP_LEFT);
         merged.right_steps[i] = (steps[i] == dqd_pkg::STEP_RIGHT);
      end
   end

   always_comb begin
      pop           = out_valid_ff && rsp_ch.ready;
      load_out      = push && (!out_valid_ff || pop);
      load_skid     = push && out_valid_ff && !pop;
      out_valid_in  = push || skid_valid_ff || (out_valid_ff && !pop);
      skid_valid_in = skid_valid_ff ? !pop : load_skid;
      // A waiting skid entry always goes ahead of a new request.
      priority if (skid_valid_ff && pop) begin
         out_data_in = skid_data_ff;
      end else if (load_out) begin
         out_data_in = merged;
      end else begin
         out_data_in = out_data_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff <= out_data_in;
      if (load_skid) begin
         skid_data_ff <= merged;
      end
   end

   assign in_ready           = !skid_valid_ff;
   assign rsp_ch.valid       = out_valid_ff;
   assign rsp_ch.left_steps  = out_data_ff.left_steps;
   assign rsp_ch.right_steps = out_data_ff.right_steps;

   assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid holds a result with the output register empty");

   assert property (@(posedge clock) disable iff (reset)
      push && out_valid_ff && !pop |=> skid_valid_ff && skid_data_ff == $past(merged))
      else $error("stalled request not captured in the skid register");

   assert property (@(posedge clock) disable iff (reset)
      !(push && skid_valid_ff))
      else $error("request taken while the skid register is full");

   assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff && pop |=> out_valid_ff && out_data_ff == $past(skid_data_ff))
      else $error("skid entry not moved to the output register");

endmodule

// ===== design/debounced_quadrature_decoder.sv =====
// Debounced quadrature decoder, one lane per encoder slot.
// A request's result is registered in the output register, or in the skid
// register while the output waits. One request per cycle while the skid is
// empty; lane state updates per accepted request, and the skid stage keeps the
// input open while one result waits. Reset (synchronous) clears all histories,
// settled pairs, the enable mask and empties both result registers.
module debounced_quadrature_decoder #(
   parameter int unsigned ENCODER_COUNT = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   dqd_req_if.sink                req_ch,
   dqd_rsp_if.source              rsp_ch,
   input  logic                   csr_we,
   input  dqd_pkg::level_vec_type csr_wdata
);

   // Slots past the field width have no pins and behave as disabled.
   localparam int unsigned LANE_COUNT =
      (ENCODER_COUNT < dqd_pkg::FIELD_BITS) ? ENCODER_COUNT : dqd_pkg::FIELD_BITS;

   dqd_pkg::level_vec_type enable_ff;
   dqd_pkg::step_code_type steps [LANE_COUNT];
   logic                   in_ready;
   logic                   push;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= '0;
      end else if (csr_we) begin
         enable_ff <= csr_wdata;
      end
   end

   assign push         = req_ch.valid && in_ready;
   assign req_ch.ready = in_ready;

   for (genvar i = 0; i < LANE_COUNT; i++) begin : g_lane
      dqd_lane u_lane (
         .clock   (clock),
         .reset   (reset),
         .accept  (push),
         .enable  (enable_ff[i]),
         .a_level (req_ch.a_levels[i]),
         .b_level (req_ch.b_levels[i]),
         .step    (steps[i])
      );
   end

   dqd_merge #(
      .LANE_COUNT (LANE_COUNT)
   ) u_merge (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .steps    (steps),
      .in_ready (in_ready),
      .rsp_ch   (rsp_ch)
   );

endmodule
